// ----- rtl/ara_pkg.sv -----
// Shared types, codes and helpers for the atlas rectangle allocator.
// Used by ara_cell, atlas_rect_allocator_top and ara_checker; no dependencies.
package ara_pkg;

	localparam int DimW = 13;
	localparam int AreaW = 2 * DimW;
	localparam int GrowStepsCap = 64;
	localparam int StepW = 7;

	localparam logic [DimW-1:0] DimMax = {DimW{1'b1}};

	// Status codes of a result word.
	localparam logic [1:0] STATUS_OK = 2'd0;
	localparam logic [1:0] STATUS_NO_ROOM = 2'd1;
	localparam logic [1:0] STATUS_LIST_FULL = 2'd2;

	// Action codes of an input word.
	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_RESTART = 1'b1;

	// Configuration register indexes.
	localparam logic [1:0] CFG_START_W = 2'd0;
	localparam logic [1:0] CFG_START_H = 2'd1;
	localparam logic [1:0] CFG_MAX_W = 2'd2;
	localparam logic [1:0] CFG_MAX_H = 2'd3;

	typedef struct packed {
		logic [DimW-1:0] left;
		logic [DimW-1:0] top;
		logic [DimW-1:0] right;
		logic [DimW-1:0] bottom;
	} rect_t;

	// Best candidate so far, handed along the row of cells.
	typedef struct packed {
		logic found;
		logic [AreaW-1:0] area;
		rect_t rect;
	} cand_t;

	// A zero dimension grows to one, any other doubles and saturates.
	function automatic logic [DimW-1:0] grow_dim(input logic [DimW-1:0] v);
		logic [DimW:0] n;
		n = {v, 1'b0};
		if (v == '0) begin
			grow_dim = {{(DimW-1){1'b0}}, 1'b1};
		end else if (n > {1'b0, DimMax}) begin
			grow_dim = DimMax;
		end else begin
			grow_dim = n[DimW-1:0];
		end
	endfunction

endpackage

// ----- rtl/ara_cell.sv -----
// One cell of the free list: holds a free rectangle and refines the best-fit
// candidate that passes through it. Depends on ara_pkg.
module ara_cell #(
	parameter int IDX = 0,
	parameter int IW = 6,
	parameter int CW = 7
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [CW-1:0]        count,
	input  logic [ara_pkg::DimW-1:0] req_w,
	input  logic [ara_pkg::DimW-1:0] req_h,
	input  logic                 wr_en,
	input  logic [IW-1:0]        wr_idx,
	input  ara_pkg::rect_t       wr_rect,
	input  ara_pkg::cand_t       cand_in,
	input  logic [IW-1:0]        idx_in,
	output ara_pkg::cand_t       cand_out,
	output logic [IW-1:0]        idx_out,
	output ara_pkg::rect_t       rect
);
	import ara_pkg::*;

	localparam logic [IW-1:0] MyIdx = IW'(IDX);
	localparam logic [CW-1:0] MyPos = CW'(IDX);

	rect_t rect_q;
	logic found_q;
	logic [AreaW-1:0] area_q;
	rect_t cand_rect_q;
	logic [IW-1:0] idx_q;
	logic [DimW-1:0] fw, fh;
	logic [AreaW-1:0] area;
	logic take;

	// Stored free rectangle; no reset, only entries below the count are read.
	always_ff @(posedge clk) begin
		if (wr_en && wr_idx == MyIdx) begin
			rect_q <= wr_rect;
		end
	end

	// Fit test and area of this entry against the request.
	always_comb begin
		fw = (rect_q.right >= rect_q.left) ? rect_q.right - rect_q.left : '0;
		fh = (rect_q.bottom >= rect_q.top) ? rect_q.bottom - rect_q.top : '0;
		area = fw * fh;
		take = (MyPos < count) && fw >= req_w && fh >= req_h &&
			(!cand_in.found || area < cand_in.area);
	end

	// Candidate register towards the next cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else begin
			found_q <= cand_in.found || take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			area_q <= area;
			cand_rect_q <= rect_q;
			idx_q <= MyIdx;
		end else begin
			area_q <= cand_in.area;
			cand_rect_q <= cand_in.rect;
			idx_q <= idx_in;
		end
	end

	assign cand_out = '{found: found_q, area: area_q, rect: cand_rect_q};
	assign idx_out = idx_q;
	assign rect = rect_q;

endmodule

// ----- rtl/atlas_rect_allocator_top.sv -----
// Atlas rectangle allocator: top level with the control sequencer and the
// row of free-list cells. Depends on ara_pkg and ara_cell.
//
// Usage: input words arrive on s_tvalid/s_tready; s_tuser carries the action
// (allocate or restart), s_tdata the requested width and height. Each word
// yields exactly one result word on m_tvalid/m_tready, with the status in
// m_tuser and the grant position and current atlas size in m_tdata.
// A restart goes straight to the done state, from which its result is
// registered into the output register. An allocation scans the free list
// through the row of cells; each growth step of the atlas costs a fresh
// scan, and a split adds a state that appends the cut-off part below.
// One word is worked on at a time; the next word is taken as soon as the
// sequencer is idle, even while the previous result waits in the output
// register. If the receiver stalls, the result is held and the sequencer
// waits with the following result until the output register is free.
// Reset empties the free list, sets the atlas size to zero, lets the width
// grow first and loads the configuration defaults (start 256 by 256,
// maximum 4096 by 4096). Configuration is written on cfg_we; the user must
// write it only while idle, as the block itself does not enforce this.
module atlas_rect_allocator_top #(
	parameter int FREE_SLOTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [12:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // req_width [12:0], req_height [25:13]
	input  logic        s_tuser,  // action [0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,  // x_pos, y_pos, atlas_width, atlas_height
	output logic [1:0]  m_tuser   // status [1:0]
);
	import ara_pkg::*;

	localparam int IW = $clog2(FREE_SLOTS);
	localparam int CW = $clog2(FREE_SLOTS + 1);
	localparam logic [CW-1:0] Slots = CW'(FREE_SLOTS);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_APP = 3'd2;
	localparam logic [2:0] ST_DONE = 3'd3;

	logic [2:0] state_q, state_d;
	logic [DimW-1:0] start_w_q, start_h_q, max_w_q, max_h_q;
	logic [DimW-1:0] cur_w_q, cur_h_q, cur_w_d, cur_h_d;
	logic grow_w_q, grow_w_d;
	logic [CW-1:0] count_q, count_d, scan_q, scan_d;
	logic [StepW-1:0] steps_q, steps_d;
	logic [DimW-1:0] req_w_q, req_h_q;
	logic [1:0] res_st_q, res_st_d;
	logic [DimW-1:0] res_x_q, res_y_q, res_x_d, res_y_d;
	rect_t pend_q, pend_d;
	logic out_v_q;
	logic [1:0] out_st_q;
	logic [55:0] out_data_q;

	logic wr_en;
	logic [IW-1:0] wr_idx;
	rect_t wr_rect;

	cand_t cand [FREE_SLOTS+1];
	logic [IW-1:0] cidx [FREE_SLOTS+1];
	rect_t cell_rect [FREE_SLOTS];

	logic in_acc, out_free;
	cand_t best;
	logic [IW-1:0] best_idx;
	rect_t f0;
	logic whole_w, whole_h, split;
	logic [DimW-1:0] nw, nh, res_right, res_bottom;

	assign in_acc = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !out_v_q || m_tready;

	// Row of cells; the first sees an empty candidate.
	assign cand[0] = '0;
	assign cidx[0] = '0;
	for (genvar g = 0; g < FREE_SLOTS; g++) begin : g_cell
		ara_cell #(.IDX(g), .IW(IW), .CW(CW)) u_cell (
			.clk(clk), .arst_n(arst_n), .count(count_q),
			.req_w(req_w_q), .req_h(req_h_q),
			.wr_en(wr_en), .wr_idx(wr_idx), .wr_rect(wr_rect),
			.cand_in(cand[g]), .idx_in(cidx[g]),
			.cand_out(cand[g+1]), .idx_out(cidx[g+1]), .rect(cell_rect[g])
		);
	end

	assign best = cand[FREE_SLOTS];
	assign best_idx = cidx[FREE_SLOTS];
	assign f0 = cell_rect[0];

	// Growth and split arithmetic.
	always_comb begin
		nw = grow_dim(cur_w_q);
		nh = grow_dim(cur_h_q);
		whole_w = count_q == CW'(1) && f0.left == '0 && f0.top == '0 &&
			f0.right == cur_w_q && f0.bottom == cur_h_q;
		whole_h = whole_w;
		res_right = best.rect.left + req_w_q;
		res_bottom = best.rect.top + req_h_q;
		split = (best.rect.bottom < best.rect.top) ||
			({1'b0, best.rect.bottom - best.rect.top} > {req_h_q, 1'b0}) ||
			(req_h_q >= (cur_h_q >> 1));
	end

	// Sequencer.
	always_comb begin
		state_d = state_q;
		cur_w_d = cur_w_q;
		cur_h_d = cur_h_q;
		grow_w_d = grow_w_q;
		count_d = count_q;
		scan_d = scan_q;
		steps_d = steps_q;
		res_st_d = res_st_q;
		res_x_d = res_x_q;
		res_y_d = res_y_q;
		pend_d = pend_q;
		wr_en = 1'b0;
		wr_idx = '0;
		wr_rect = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					res_st_d = STATUS_OK;
					res_x_d = '0;
					res_y_d = '0;
					if (s_tuser == ACT_RESTART) begin
						cur_w_d = start_w_q;
						cur_h_d = start_h_q;
						grow_w_d = 1'b1;
						count_d = CW'(1);
						wr_en = 1'b1;
						wr_rect = '{left: '0, top: '0, right: start_w_q, bottom: start_h_q};
						state_d = ST_DONE;
					end else begin
						scan_d = '0;
						steps_d = '0;
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				scan_d = scan_q + CW'(1);
				if (scan_q == Slots) begin
					scan_d = '0;
					if (best.found) begin
						if (split && count_q >= Slots) begin
							res_st_d = STATUS_LIST_FULL;
							state_d = ST_DONE;
						end else begin
							wr_en = 1'b1;
							wr_idx = best_idx;
							wr_rect = best.rect;
							wr_rect.left = res_right;
							res_x_d = best.rect.left;
							res_y_d = best.rect.top;
							pend_d = '{left: best.rect.left, top: res_bottom,
								right: best.rect.right, bottom: best.rect.bottom};
							if (split) begin
								wr_rect.bottom = res_bottom;
								state_d = ST_APP;
							end else begin
								state_d = ST_DONE;
							end
						end
					end else if (steps_q >= StepW'(GrowStepsCap)) begin
						res_st_d = STATUS_NO_ROOM;
						state_d = ST_DONE;
					end else if (grow_w_q && cur_w_q < max_w_q) begin
						if (whole_w) begin
							wr_en = 1'b1;
							wr_rect = '{left: '0, top: '0, right: nw, bottom: cur_h_q};
						end else if (count_q >= Slots) begin
							res_st_d = STATUS_LIST_FULL;
							state_d = ST_DONE;
						end else begin
							wr_en = 1'b1;
							wr_idx = count_q[IW-1:0];
							wr_rect = '{left: cur_w_q, top: '0, right: nw, bottom: cur_h_q};
							count_d = count_q + CW'(1);
						end
						if (whole_w || count_q < Slots) begin
							cur_w_d = nw;
							grow_w_d = 1'b0;
							steps_d = steps_q + StepW'(1);
						end
					end else if (!grow_w_q && cur_h_q < max_h_q) begin
						if (whole_h) begin
							wr_en = 1'b1;
							wr_rect = '{left: '0, top: '0, right: cur_w_q, bottom: nh};
						end else if (count_q >= Slots) begin
							res_st_d = STATUS_LIST_FULL;
							state_d = ST_DONE;
						end else begin
							wr_en = 1'b1;
							wr_idx = count_q[IW-1:0];
							wr_rect = '{left: '0, top: cur_h_q, right: cur_w_q, bottom: nh};
							count_d = count_q + CW'(1);
						end
						if (whole_h || count_q < Slots) begin
							cur_h_d = nh;
							grow_w_d = 1'b1;
							steps_d = steps_q + StepW'(1);
						end
					end else begin
						res_st_d = STATUS_NO_ROOM;
						state_d = ST_DONE;
					end
				end
			end
			ST_APP: begin
				wr_en = 1'b1;
				wr_idx = count_q[IW-1:0];
				wr_rect = pend_q;
				count_d = count_q + CW'(1);
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cur_w_q <= '0;
			cur_h_q <= '0;
			grow_w_q <= 1'b1;
			count_q <= '0;
			scan_q <= '0;
			steps_q <= '0;
			start_w_q <= DimW'(256);
			start_h_q <= DimW'(256);
			max_w_q <= DimW'(4096);
			max_h_q <= DimW'(4096);
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cur_w_q <= cur_w_d;
			cur_h_q <= cur_h_d;
			grow_w_q <= grow_w_d;
			count_q <= count_d;
			scan_q <= scan_d;
			steps_q <= steps_d;
			if (cfg_we) begin
				unique case (cfg_addr)
					CFG_START_W: start_w_q <= cfg_wdata;
					CFG_START_H: start_h_q <= cfg_wdata;
					CFG_MAX_W: max_w_q <= cfg_wdata;
					CFG_MAX_H: max_h_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (state_q == ST_DONE && out_free) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_w_q <= s_tdata[12:0];
			req_h_q <= s_tdata[25:13];
		end
		res_st_q <= res_st_d;
		res_x_q <= res_x_d;
		res_y_q <= res_y_d;
		pend_q <= pend_d;
		if (state_q == ST_DONE && out_free) begin
			out_st_q <= res_st_q;
			out_data_q <= {4'b0, cur_h_q, cur_w_q, res_y_q, res_x_q};
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser = out_st_q;
	assign m_tdata = out_data_q;

endmodule

// ----- rtl/ara_checker.sv -----
// Port-level checks for the atlas rectangle allocator, bound to its top level.
// Depends on ara_pkg.
module ara_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata,
	input logic [1:0]  m_tuser
);
	import ara_pkg::*;

	// A stalled result word holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	// Only the three defined status codes appear.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == STATUS_OK || m_tuser == STATUS_NO_ROOM ||
			m_tuser == STATUS_LIST_FULL))
		else $error("undefined status code");

	// A refused allocation reports a zero position.
	a_zero_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != STATUS_OK |-> m_tdata[25:0] == '0)
		else $error("position not zero on a refused allocation");

endmodule

bind atlas_rect_allocator_top ara_checker u_ara_checker (
	.clk(clk), .arst_n(arst_n), .m_tvalid(m_tvalid), .m_tready(m_tready),
	.m_tdata(m_tdata), .m_tuser(m_tuser)
);

// ----- verif/atlas_rect_allocator_top_tb.sv -----
// Self-checking testbench for atlas_rect_allocator_top: a directed table, then
// random words; checked by a behavioural atlas model or typed expected results.
// Depends on ara_pkg and the allocator RTL.
module atlas_rect_allocator_top_tb;
	import ara_pkg::*;

	localparam int Slots = 64;
	localparam int StepCap = 64;
	localparam int DimSat = 8191;
	localparam int CycleLimit = 20000000;
	localparam int DrainCycles = 300;
	localparam int NumPhases = 6;
	localparam int RandPerPhase = 88;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_addr;
	logic [12:0] cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;
	logic [1:0]  m_tuser;

	typedef struct {
		logic [1:0] status;
		int unsigned x;
		int unsigned y;
		int unsigned aw;
		int unsigned ah;
	} grant_t;

	typedef struct {
		logic act;
		int unsigned w;
		int unsigned h;
		bit typed;
		grant_t want;
	} row_t;

	// Model state of the atlas and its free list.
	int unsigned fr_left [Slots];
	int unsigned fr_top [Slots];
	int unsigned fr_right [Slots];
	int unsigned fr_bottom [Slots];
	int unsigned fr_count;
	int unsigned atlas_w;
	int unsigned atlas_h;
	bit          widen_next;
	int unsigned reg_start_w;
	int unsigned reg_start_h;
	int unsigned reg_max_w;
	int unsigned reg_max_h;

	grant_t pending_grants[$];
	int     mismatches = 0;
	int     cycles = 0;
	bit     no_idle;
	bit     recv_stall_ok;
	row_t   dir_rows[$];

	atlas_rect_allocator_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int unsigned doubled(int unsigned v);
		if (v == 0) begin
			return 1;
		end
		return (v * 2 > DimSat) ? DimSat : v * 2;
	endfunction

	function automatic void fr_push(int unsigned l, int unsigned t, int unsigned r,
			int unsigned b);
		fr_left[fr_count] = l;
		fr_top[fr_count] = t;
		fr_right[fr_count] = r;
		fr_bottom[fr_count] = b;
		fr_count++;
	endfunction

	// Works out the result word of one input word and updates the atlas state.
	function automatic grant_t pack_rect(logic act, int unsigned rw, int unsigned rh);
		grant_t g;
		int unsigned best, best_area, fw, fh, a, old, nw, x, y, bh;
		bit found, split;
		g = '{STATUS_OK, 0, 0, 0, 0};
		best = 0;
		best_area = 0;
		if (act == ACT_RESTART) begin
			atlas_w = reg_start_w;
			atlas_h = reg_start_h;
			widen_next = 1'b1;
			fr_count = 0;
			fr_push(0, 0, reg_start_w, reg_start_h);
			g.aw = atlas_w;
			g.ah = atlas_h;
			return g;
		end
		for (int steps = 0; steps <= StepCap; steps++) begin
			found = 1'b0;
			for (int i = 0; i < fr_count; i++) begin
				fw = (fr_right[i] >= fr_left[i]) ? fr_right[i] - fr_left[i] : 0;
				fh = (fr_bottom[i] >= fr_top[i]) ? fr_bottom[i] - fr_top[i] : 0;
				if (fw >= rw && fh >= rh) begin
					a = fw * fh;
					if (!found || a < best_area) begin
						found = 1'b1;
						best = i;
						best_area = a;
					end
				end
			end
			if (found) begin
				break;
			end
			g.aw = atlas_w;
			g.ah = atlas_h;
			if (steps >= StepCap) begin
				g.status = STATUS_NO_ROOM;
				return g;
			end
			if (widen_next && atlas_w < reg_max_w) begin
				old = atlas_w;
				nw = doubled(old);
				if (fr_count == 1 && fr_left[0] == 0 && fr_top[0] == 0 &&
						fr_right[0] == old && fr_bottom[0] == atlas_h) begin
					fr_right[0] = nw;
				end else if (fr_count >= Slots) begin
					g.status = STATUS_LIST_FULL;
					return g;
				end else begin
					fr_push(old, 0, nw, atlas_h);
				end
				atlas_w = nw;
			end else if (!widen_next && atlas_h < reg_max_h) begin
				old = atlas_h;
				nw = doubled(old);
				if (fr_count == 1 && fr_left[0] == 0 && fr_top[0] == 0 &&
						fr_right[0] == atlas_w && fr_bottom[0] == old) begin
					fr_bottom[0] = nw;
				end else if (fr_count >= Slots) begin
					g.status = STATUS_LIST_FULL;
					return g;
				end else begin
					fr_push(0, old, atlas_w, nw);
				end
				atlas_h = nw;
			end else begin
				g.status = STATUS_NO_ROOM;
				return g;
			end
			widen_next = !widen_next;
		end
		g.aw = atlas_w;
		g.ah = atlas_h;
		// Fast split: keep the part to the right, optionally cut off the part below.
		bh = fr_bottom[best] - fr_top[best];
		split = (bh > 2 * rh) || (rh >= atlas_h / 2);
		x = fr_left[best];
		y = fr_top[best];
		if (split && fr_count >= Slots) begin
			g.status = STATUS_LIST_FULL;
			return g;
		end
		fr_left[best] = x + rw;
		if (split) begin
			fr_push(x, y + rh, fr_right[best], fr_bottom[best]);
			fr_bottom[best] = y + rh;
		end
		g.x = x;
		g.y = y;
		return g;
	endfunction

	// Receiver readiness: a random hold-off before every result word, none while no_idle is set.
	initial begin
		int gap;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = (no_idle || !recv_stall_ok) ? 0 : $urandom_range(0, 9);
			@(negedge clk);
			if (gap > 0) begin
				m_tready = 1'b0;
				repeat (gap - 1) @(negedge clk);
				@(negedge clk);
			end
			m_tready = 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// Result checker: every accepted word against the oldest expectation.
	always @(posedge clk) begin
		grant_t w;
		if (m_tvalid && m_tready) begin
			if (pending_grants.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected result word: status %0d data %h", m_tuser, m_tdata);
				end
			end else begin
				w = pending_grants.pop_front();
				if (m_tuser !== w.status || m_tdata[12:0] !== w.x[12:0] ||
						m_tdata[25:13] !== w.y[12:0] || m_tdata[38:26] !== w.aw[12:0] ||
						m_tdata[51:39] !== w.ah[12:0] || m_tdata[55:52] !== 4'd0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: want st %0d x %0d y %0d w %0d h %0d",
							w.status, w.x, w.y, w.aw, w.ah);
						$display("          got  st %0d x %0d y %0d w %0d h %0d",
							m_tuser, m_tdata[12:0], m_tdata[25:13], m_tdata[38:26],
							m_tdata[51:39]);
					end
				end
			end
		end
	end

	// Run limit.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("atlas_rect_allocator_top_tb: done, errors");
			$finish;
		end
	end

	// Sends one word; entered and left at a falling edge.
	task automatic send_word(logic act, int unsigned w, int unsigned h, bit typed,
			grant_t want);
		int gap;
		grant_t g;
		gap = no_idle ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tuser = act;
		s_tdata = {6'd0, h[12:0], w[12:0]};
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		g = pack_rect(act, w, h);
		if (typed) begin
			g = want;
		end
		pending_grants.insert(pending_grants.size(), g);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid = 1'b0;
		while (pending_grants.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, int unsigned v);
		cfg_we = 1'b1;
		cfg_addr = idx;
		cfg_wdata = v[12:0];
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			CFG_START_W: begin reg_start_w = v; end
			CFG_START_H: begin reg_start_h = v; end
			CFG_MAX_W: begin reg_max_w = v; end
			default: begin reg_max_h = v; end
		endcase
	endtask

	function automatic int unsigned rand_dim();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			return $urandom_range(0, 15);
		end else if (pick < 90) begin
			return $urandom_range(0, 255);
		end else if (pick < 97) begin
			return $urandom_range(0, 4095);
		end
		return (pick == 99) ? 0 : 4096;
	endfunction

	initial begin
		grant_t none;
		int unsigned cfg_sets [NumPhases][4];
		none = '{STATUS_OK, 0, 0, 0, 0};
		cfg_sets = '{'{1, 1, 4096, 4096}, '{4096, 4096, 4096, 4096},
			'{16, 8, 64, 32}, '{1, 1, 1, 1}, '{3, 5, 4096, 1}, '{100, 1, 200, 4096}};
		no_idle = 1'b0;
		recv_stall_ok = 1'b1;
		fr_count = 0;
		atlas_w = 0;
		atlas_h = 0;
		widen_next = 1'b1;
		reg_start_w = 256;
		reg_start_h = 256;
		reg_max_w = 4096;
		reg_max_h = 4096;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = ACT_ALLOC;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed words; the first three have results that are plain to see.
		dir_rows = '{
			'{ACT_ALLOC, 0, 0, 1, '{STATUS_OK, 0, 0, 1, 0}},
			'{ACT_RESTART, 4096, 4096, 1, '{STATUS_OK, 0, 0, 256, 256}},
			'{ACT_ALLOC, 256, 256, 1, '{STATUS_OK, 0, 0, 256, 256}},
			'{ACT_ALLOC, 0, 0, 0, none},
			'{ACT_ALLOC, 1, 1, 0, none},
			'{ACT_ALLOC, 4096, 4096, 0, none},
			'{ACT_ALLOC, 4096, 0, 0, none},
			'{ACT_ALLOC, 0, 4096, 0, none},
			'{ACT_ALLOC, 4095, 1, 0, none},
			'{ACT_RESTART, 0, 0, 0, none},
			'{ACT_ALLOC, 128, 64, 0, none},
			'{ACT_ALLOC, 128, 64, 0, none},
			'{ACT_ALLOC, 300, 10, 0, none},
			'{ACT_ALLOC, 2730, 5461, 0, none},
			'{ACT_ALLOC, 1365, 2730, 0, none},
			'{ACT_ALLOC, 4096, 4096, 0, none}
		};
		foreach (dir_rows[i]) begin
			send_word(dir_rows[i].act, dir_rows[i].w, dir_rows[i].h, dir_rows[i].typed,
				dir_rows[i].want);
		end

		// Random phases, each under its own register setting.
		for (int p = 0; p < NumPhases; p++) begin
			wait_drained();
			for (int r = 0; r < 4; r++) begin
				write_reg(r[1:0], cfg_sets[p][r]);
			end
			no_idle = (p == 2);
			send_word(ACT_RESTART, $urandom_range(0, 4096), $urandom_range(0, 4096), 0, none);
			for (int n = 0; n < RandPerPhase; n++) begin
				if (n == RandPerPhase / 2 && p == 1) begin
					// Let every outstanding result arrive before going on.
					s_tvalid = 1'b0;
					while (pending_grants.size() != 0) @(negedge clk);
				end
				send_word(($urandom_range(0, 11) == 0) ? ACT_RESTART : ACT_ALLOC,
					rand_dim(), rand_dim(), 0, none);
			end
		end

		// Drain the remaining results, then a final quiet spell.
		s_tvalid = 1'b0;
		while (pending_grants.size() != 0) @(negedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (mismatches == 0 && pending_grants.size() == 0) begin
			$display("atlas_rect_allocator_top_tb: done, clean");
		end else begin
			$display("atlas_rect_allocator_top_tb: done, errors");
		end
		$finish;
	end

endmodule
